// ----- rtl/rlba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlba_pkg
// Shared types and constants for the run-list block allocator.
// ----------------------------------------------------------------------------
package rlba_pkg;

	localparam int MAX_RUNS = 32;
	localparam int IDX_W    = $clog2(MAX_RUNS);
	localparam int CNT_W    = IDX_W + 1;
	localparam int BLK_W    = 16;
	localparam int END_W    = BLK_W + 1;

	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE  = 2'd1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
	localparam logic [1:0] ST_TBL_FULL  = 2'd3;

	typedef struct packed {
		logic [END_W-1:0] e;
		logic [BLK_W-1:0] s;
	} run_t;

	localparam int RUN_W = $bits(run_t);

	typedef struct packed {
		logic [1:0]       status;
		logic             ok;
		logic             wr;
		logic [IDX_W-1:0] wr_idx;
		run_t             wr_run;
		logic             rm;
		logic             ins;
		logic [CNT_W-1:0] pos;
		run_t             nrun;
		logic [BLK_W-1:0] grant;
	} dec_t;

endpackage

// ----- rtl/rlba_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rlba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/rlba_stat.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlba_stat
// Capacity check and lowest free block from the counters and the head run.
// ----------------------------------------------------------------------------
module rlba_stat import rlba_pkg::*; (
	input  logic [BLK_W-1:0] total,
	input  logic [END_W-1:0] count,
	input  logic [BLK_W-1:0] amount,
	input  run_t             head,
	input  logic [CNT_W-1:0] used,
	output logic             enough,
	output logic [BLK_W-1:0] next_free
);

	logic signed [END_W:0] avail;

	// gaps telescope: free = total - allocated
	assign avail     = $signed({1'b0, total} - {1'b0, count});
	assign enough    = $signed({2'b00, amount}) <= avail;
	assign next_free = (used != '0 && head.s == '0) ? head.e[BLK_W-1:0] : '0;

endmodule

// ----- rtl/run_list_block_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_list_block_allocator
// Sorted run table allocator: lowest-free allocate, free with remove/trim/split, query.
// ----------------------------------------------------------------------------
// Channel | Dir | Fields (low bit up)
// s_*     | in  | tuser: mode[1:0]; tdata: block_index[15:0], amount[31:16]
// m_*     | out | tdata: status, granted_block, enough_free, allocated_count,
//         |     |        next_free, run_count, zero pad to 64
// cfg_*   | in  | wdata: total_blocks[15:0]
//
// Query reads the head run only. Allocate reads runs 0 and 1, then shifts runs
// on merge or insert. Free searches runs in order, then shifts runs on remove
// or split; each shifted run is one read and one write.
// Every step uses the single run-table RAM port pair, one access per step.
// Reset clears run count and allocated count; table contents need no clear.
// A waiting result holds the sequencer before the next result is loaded.
// ----------------------------------------------------------------------------
module run_list_block_allocator import rlba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,   // total_blocks
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,     // mode
	input  logic [31:0] s_tdata,     // block_index, amount
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata      // status, granted_block, enough_free,
	                                 // allocated_count, next_free, run_count
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_A_RD0  = 4'd1;
	localparam logic [3:0] S_A_RD1  = 4'd2;
	localparam logic [3:0] S_A_DEC  = 4'd3;
	localparam logic [3:0] S_F_RD   = 4'd4;
	localparam logic [3:0] S_F_CHK  = 4'd5;
	localparam logic [3:0] S_SH_CHK = 4'd6;
	localparam logic [3:0] S_SH_RD  = 4'd7;
	localparam logic [3:0] S_SH_WR  = 4'd8;
	localparam logic [3:0] S_INS_W  = 4'd9;
	localparam logic [3:0] S_H_RD   = 4'd10;
	localparam logic [3:0] S_H_CAP  = 4'd11;

	logic [3:0]       state_q;
	logic [BLK_W-1:0] total_q;
	logic [CNT_W-1:0] used_q;
	logic [END_W-1:0] count_q;
	logic [1:0]       mode_q;
	logic [BLK_W-1:0] blk_q;
	logic [BLK_W-1:0] amt_q;
	logic [1:0]       status_q;
	logic [BLK_W-1:0] grant_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] p_q;
	logic             rm_q;
	run_t             new_q;
	run_t             r0_q;
	logic [63:0]      out_q;
	logic             out_v_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	run_t             ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	run_t             rd;
	logic [RUN_W-1:0] rd_bits;
	dec_t             dec;
	logic             hit;
	logic             enough;
	logic [BLK_W-1:0] next_free;
	logic [CNT_W-1:0] k_inc;
	logic [CNT_W-1:0] k_dec;
	logic [END_W-1:0] cand;
	logic             out_load;

	assign rd    = run_t'(rd_bits);
	assign k_inc = k_q + 1'b1;
	assign k_dec = k_q - 1'b1;
	assign hit   = rd.s <= blk_q && rd.e > {1'b0, blk_q};
	assign cand  = (used_q == '0 || r0_q.s != '0) ? '0 : r0_q.e;

	assign out_load = state_q == S_H_CAP && (!out_v_q || m_tready);

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	rlba_ram #(.WIDTH(RUN_W), .DEPTH(MAX_RUNS)) u_tbl (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_bits)
	);

	rlba_stat u_stat (
		.total     (total_q),
		.count     (count_q),
		.amount    (amt_q),
		.head      (rd),
		.used      (used_q),
		.enough    (enough),
		.next_free (next_free)
	);

	// decision for the current request
	always_comb begin
		dec        = '0;
		dec.status = ST_OK;
		if (state_q == S_A_DEC) begin
			if (cand >= {1'b0, total_q}) begin
				dec.status = ST_FULL;
			end else if (used_q == '0) begin
				dec.ok   = 1'b1;
				dec.ins  = 1'b1;
				dec.nrun = '{e: END_W'(1), s: '0};
			end else if (r0_q.s != '0) begin
				if (r0_q.s == BLK_W'(1)) begin
					dec.ok     = 1'b1;
					dec.wr     = 1'b1;
					dec.wr_run = '{e: r0_q.e, s: '0};
				end else if (used_q >= CNT_W'(MAX_RUNS)) begin
					dec.status = ST_TBL_FULL;
				end else begin
					dec.ok   = 1'b1;
					dec.ins  = 1'b1;
					dec.nrun = '{e: END_W'(1), s: '0};
				end
			end else if (used_q > CNT_W'(1) &&
			             ({1'b0, r0_q.e} + 1'b1) >= {2'b00, rd.s}) begin
				dec.ok     = 1'b1;
				dec.wr     = 1'b1;
				dec.wr_run = '{e: rd.e, s: '0};
				dec.rm     = 1'b1;
				dec.pos    = CNT_W'(1);
			end else begin
				dec.ok     = 1'b1;
				dec.wr     = 1'b1;
				dec.wr_run = '{e: r0_q.e + 1'b1, s: '0};
			end
			if (dec.ok) begin
				dec.grant = cand[BLK_W-1:0];
			end
		end else if (state_q == S_F_CHK && hit) begin
			dec.wr_idx = ptr_q[IDX_W-1:0];
			if (({1'b0, rd.s} + 1'b1) == rd.e) begin
				dec.ok  = 1'b1;
				dec.rm  = 1'b1;
				dec.pos = ptr_q;
			end else if (rd.s == blk_q) begin
				dec.ok     = 1'b1;
				dec.wr     = 1'b1;
				dec.wr_run = '{e: rd.e, s: rd.s + 1'b1};
			end else if ((rd.e - 1'b1) == {1'b0, blk_q}) begin
				dec.ok     = 1'b1;
				dec.wr     = 1'b1;
				dec.wr_run = '{e: rd.e - 1'b1, s: rd.s};
			end else if (used_q >= CNT_W'(MAX_RUNS)) begin
				dec.status = ST_TBL_FULL;
			end else begin
				dec.ok     = 1'b1;
				dec.wr     = 1'b1;
				dec.wr_run = '{e: {1'b0, blk_q}, s: rd.s};
				dec.ins    = 1'b1;
				dec.pos    = ptr_q + 1'b1;
				dec.nrun   = '{e: rd.e, s: blk_q + 1'b1};
			end
		end
	end

	// table port muxing
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = dec.wr_idx;
		ram_wdata = dec.wr_run;
		ram_raddr = '0;
		unique case (state_q)
			S_A_RD1: ram_raddr = IDX_W'(1);
			S_F_RD:  ram_raddr = ptr_q[IDX_W-1:0];
			S_A_DEC, S_F_CHK: ram_we = dec.wr;
			S_SH_RD: ram_raddr = rm_q ? k_inc[IDX_W-1:0] : k_dec[IDX_W-1:0];
			S_SH_WR: begin
				ram_we    = 1'b1;
				ram_waddr = k_q[IDX_W-1:0];
				ram_wdata = rd;
			end
			S_INS_W: begin
				ram_we    = 1'b1;
				ram_waddr = p_q[IDX_W-1:0];
				ram_wdata = new_q;
			end
			default: ram_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			used_q  <= '0;
			count_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				total_q <= cfg_wdata;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						mode_q   <= s_tuser;
						blk_q    <= s_tdata[15:0];
						amt_q    <= s_tdata[31:16];
						status_q <= ST_OK;
						grant_q  <= '0;
						ptr_q    <= '0;
						if (s_tuser == MODE_ALLOC) begin
							state_q <= S_A_RD0;
						end else if (s_tuser == MODE_FREE) begin
							if (used_q == '0) begin
								status_q <= ST_NOT_ALLOC;
								state_q  <= S_H_RD;
							end else begin
								state_q <= S_F_RD;
							end
						end else begin
							state_q <= S_H_RD;
						end
					end
				end
				S_A_RD0: state_q <= S_A_RD1;
				S_A_RD1: begin
					r0_q    <= rd;
					state_q <= S_A_DEC;
				end
				S_F_RD: state_q <= S_F_CHK;
				S_A_DEC, S_F_CHK: begin
					if (state_q == S_F_CHK && !hit) begin
						if (ptr_q + 1'b1 < used_q) begin
							ptr_q   <= ptr_q + 1'b1;
							state_q <= S_F_RD;
						end else begin
							status_q <= ST_NOT_ALLOC;
							state_q  <= S_H_RD;
						end
					end else begin
						status_q <= dec.status;
						grant_q  <= dec.grant;
						rm_q     <= dec.rm;
						p_q      <= dec.pos;
						new_q    <= dec.nrun;
						k_q      <= dec.rm ? dec.pos : used_q;
						if (dec.ok) begin
							count_q <= (mode_q == MODE_ALLOC) ? count_q + 1'b1 :
							                                    count_q - 1'b1;
						end
						state_q <= (dec.rm || dec.ins) ? S_SH_CHK : S_H_RD;
					end
				end
				S_SH_CHK: begin
					if (rm_q) begin
						if (k_inc < used_q) begin
							state_q <= S_SH_RD;
						end else begin
							used_q  <= used_q - 1'b1;
							state_q <= S_H_RD;
						end
					end else begin
						state_q <= (k_q > p_q) ? S_SH_RD : S_INS_W;
					end
				end
				S_SH_RD: state_q <= S_SH_WR;
				S_SH_WR: begin
					k_q     <= rm_q ? k_inc : k_dec;
					state_q <= S_SH_CHK;
				end
				S_INS_W: begin
					used_q  <= used_q + 1'b1;
					state_q <= S_H_RD;
				end
				S_H_RD: state_q <= S_H_CAP;
				S_H_CAP: begin
					if (out_load) begin
						out_q   <= {7'd0, used_q, next_free, count_q[BLK_W-1:0],
						            enough, grant_q, status_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_used_max: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(MAX_RUNS))
		else $error("run count above table depth");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> (used_q == '0) == (count_q == '0))
		else $error("run count and allocated count disagree");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted item while busy");

	a_grant: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[17:2] == '0)
		else $error("grant reported on failed request");

endmodule

// ----- verif/run_list_block_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_list_block_allocator_tb
// Streams allocate, free and query requests into the allocator under random
// idling on both sides and checks every result against a run-table model.
// The model tracks runs, table fill, store-full and table-full refusals, and
// the capacity check. total_blocks is changed between phases while idle.
// ----------------------------------------------------------------------------
module run_list_block_allocator_tb;
	import rlba_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE      = 250;
	localparam logic [1:0] MODE_QUERY  = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] granted;
		logic        enough;
		logic [15:0] alloc_cnt;
		logic [15:0] next_free;
		logic [5:0]  runs;
	} alloc_result_t;

	class run_table_scoreboard;
		logic [15:0]   run_lo[MAX_RUNS];
		logic [16:0]   run_hi[MAX_RUNS];
		int            used;
		logic [15:0]   total;
		alloc_result_t pending[$];
		int            errors;
		int            checked;
		int            refusals;
		int            full_tables;

		function void set_total(logic [15:0] v);
			total = v;
		endfunction

		function logic [16:0] lowest_free();
			if (used == 0 || run_lo[0] != 0)
				return 0;
			return run_hi[0];
		endfunction

		function logic [16:0] top_end();
			return (used == 0) ? 17'd0 : run_hi[used-1];
		endfunction

		function void drop_run(int at);
			for (int k = at; k + 1 < used; k++) begin
				run_lo[k] = run_lo[k+1];
				run_hi[k] = run_hi[k+1];
			end
			used--;
		endfunction

		function void add_run(int at, logic [16:0] lo, logic [16:0] hi);
			for (int k = used; k > at; k--) begin
				run_lo[k] = run_lo[k-1];
				run_hi[k] = run_hi[k-1];
			end
			run_lo[at] = lo[15:0];
			run_hi[at] = hi;
			used++;
		endfunction

		function logic [1:0] grant_block(output logic [15:0] granted);
			logic [16:0] cand;
			cand = lowest_free();
			granted = 0;
			if (cand >= total)
				return ST_FULL;
			if (used == 0) begin
				add_run(0, 0, 1);
			end else if (run_lo[0] != 0) begin
				if (run_lo[0] == 1) begin
					run_lo[0] = 0;
				end else begin
					if (used >= MAX_RUNS)
						return ST_TBL_FULL;
					add_run(0, 0, 1);
				end
			end else if (used > 1 && run_hi[0] + 1 >= run_lo[1]) begin
				run_hi[0] = run_hi[1];
				drop_run(1);
			end else begin
				run_hi[0] = run_hi[0] + 1;
			end
			granted = cand[15:0];
			return ST_OK;
		endfunction

		function logic [1:0] release_block(logic [15:0] blk);
			int i;
			logic [16:0] lo, hi;
			for (i = 0; i < used; i++)
				if (run_lo[i] <= blk && run_hi[i] > blk)
					break;
			if (i == used)
				return ST_NOT_ALLOC;
			lo = run_lo[i];
			hi = run_hi[i];
			if (lo + 1 == hi) begin
				drop_run(i);
			end else if (lo == blk) begin
				run_lo[i] = lo + 1;
			end else if (hi - 1 == blk) begin
				run_hi[i] = hi - 1;
			end else begin
				if (used >= MAX_RUNS)
					return ST_TBL_FULL;
				run_hi[i] = blk;
				add_run(i + 1, blk + 1, hi);
			end
			return ST_OK;
		endfunction

		function void note(logic [1:0] mode, logic [15:0] blk, logic [15:0] amt);
			alloc_result_t r;
			longint avail;
			longint sum;
			r.granted = 0;
			r.status = ST_OK;
			if (mode == MODE_ALLOC)
				r.status = grant_block(r.granted);
			else if (mode == MODE_FREE)
				r.status = release_block(blk);
			if (r.status != ST_OK)
				refusals++;
			if (used == MAX_RUNS)
				full_tables++;
			sum = 0;
			if (used == 0) begin
				avail = total;
			end else begin
				avail = run_lo[0];
				for (int i = 1; i < used; i++)
					avail += longint'(run_lo[i]) - longint'(run_hi[i-1]);
				avail += longint'(total) - longint'(run_hi[used-1]);
			end
			for (int i = 0; i < used; i++)
				sum += run_hi[i] - run_lo[i];
			r.enough = (longint'(amt) <= avail);
			r.alloc_cnt = sum[15:0];
			r.next_free = lowest_free();
			r.runs = used[5:0];
			pending.push_back(r);
		endfunction

		function void check(logic [63:0] d);
			alloc_result_t e, a;
			a.status = d[1:0];
			a.granted = d[17:2];
			a.enough = d[18];
			a.alloc_cnt = d[34:19];
			a.next_free = d[50:35];
			a.runs = d[56:51];
			if (pending.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual %h", $realtime, d);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (a.status != e.status)
				$display("%0t: status expected %0d actual %0d", $realtime, e.status, a.status);
			if (a.granted != e.granted)
				$display("%0t: granted_block expected %0d actual %0d", $realtime,
					e.granted, a.granted);
			if (a.enough != e.enough)
				$display("%0t: enough_free expected %0d actual %0d", $realtime,
					e.enough, a.enough);
			if (a.alloc_cnt != e.alloc_cnt)
				$display("%0t: allocated_count expected %0d actual %0d", $realtime,
					e.alloc_cnt, a.alloc_cnt);
			if (a.next_free != e.next_free)
				$display("%0t: next_free expected %0d actual %0d", $realtime,
					e.next_free, a.next_free);
			if (a.runs != e.runs)
				$display("%0t: run_count expected %0d actual %0d", $realtime, e.runs, a.runs);
			if (a != e || d[63:57] != 0)
				errors++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [1:0]  s_tuser;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;

	run_table_scoreboard sb;
	bit idle_on;
	bit hold_req;
	int stall_cnt;
	int sent;

	run_list_block_allocator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt > STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side: random stalls, one long hold on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
			end
			m_tready = 1'b1;
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check(m_tdata);
		end
	end

	task automatic send_req(logic [1:0] mode, logic [15:0] blk, logic [15:0] amt);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = mode;
		s_tdata = {amt, blk};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note(mode, blk, amt);
		sent++;
		@(negedge clk);
	endtask

	task automatic set_total(logic [15:0] v);
		s_tvalid = 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_total(v);
	endtask

	function automatic logic [15:0] rand_amount(logic [15:0] tot);
		if ($urandom_range(0, 4) == 0)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, int'(tot) + 8 > 65535 ? 65535 : int'(tot) + 8));
	endfunction

	task automatic random_phase(int n, logic [15:0] tot);
		int pick;
		int hi;
		logic [15:0] blk;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			hi = int'(sb.top_end()) + 3;
			blk = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, hi))
				: 16'($urandom_range(0, 65535));
			if (pick < 47)
				send_req(MODE_ALLOC, 16'($urandom), rand_amount(tot));
			else if (pick < 88)
				send_req(MODE_FREE, blk, rand_amount(tot));
			else if (pick < 95)
				send_req(MODE_QUERY, 16'($urandom), rand_amount(tot));
			else
				send_req(MODE_UNUSED, blk, rand_amount(tot));
		end
	endtask

	initial begin
		sb = new();
		sb.total = 0;
		sb.used = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 16'd0;
		s_tvalid = 1'b0;
		s_tuser = 2'd0;
		s_tdata = 32'd0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		stall_cnt = 0;
		sent = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty store
		send_req(MODE_ALLOC, 16'hFFFF, 16'd0);
		send_req(MODE_QUERY, 16'd0, 16'd1);
		send_req(MODE_FREE, 16'd0, 16'hFFFF);
		send_req(MODE_UNUSED, 16'hFFFF, 16'd0);

		// fill the run table, then hit both full-table refusals
		set_total(16'hFFFF);
		for (int k = 0; k < 66; k++)
			send_req(MODE_ALLOC, 16'd0, (k == 0) ? 16'hFFFF : 16'($urandom));
		for (int b = 1; b < 62; b += 2)
			send_req(MODE_FREE, 16'(b), 16'd65470);
		send_req(MODE_FREE, 16'd63, 16'd65469);
		send_req(MODE_FREE, 16'd64, 16'd0);
		send_req(MODE_FREE, 16'd0, 16'hFFFF);
		send_req(MODE_FREE, 16'd65, 16'd1);
		send_req(MODE_FREE, 16'd63, 16'd2);
		send_req(MODE_ALLOC, 16'd0, 16'd0);
		send_req(MODE_FREE, 16'd2, 16'd0);
		send_req(MODE_ALLOC, 16'd0, 16'd0);
		send_req(MODE_FREE, 16'hFFFF, 16'hFFFF);
		send_req(MODE_FREE, 16'h8000, 16'h7FFF);

		// capacity below allocated runs
		set_total(16'd10);
		send_req(MODE_QUERY, 16'd0, 16'd0);
		send_req(MODE_ALLOC, 16'd0, 16'd0);

		hold_req = 1'b1;
		random_phase(200, 16'd10);
		set_total(16'hFFFF);
		random_phase(200, 16'hFFFF);
		set_total(16'd37);
		random_phase(180, 16'd37);
		set_total(16'd1);
		random_phase(100, 16'd1);
		set_total(16'd300);
		random_phase(200, 16'd300);
		set_total(16'd50);
		idle_on = 1'b0;
		random_phase(150, 16'd50);

		s_tvalid = 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		$display("Sent %0d requests, checked %0d results, %0d refused.", sent,
			sb.checked, sb.refusals);
		$display("Run table reached full capacity on %0d results.", sb.full_tables);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/rlba_pkg.sv
rtl/rlba_ram.sv
rtl/rlba_stat.sv
rtl/run_list_block_allocator.sv
verif/run_list_block_allocator_tb.sv
